// File: src/spfsp_pkg.sv
// Shared definitions for the sparse frequent-submatrix projection unit.
// Field widths, mode and result codes, register indexes and the per-axis control struct.
// No dependencies.
`timescale 1ns / 1ps

package spfsp_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int unsigned MAX_ROWS_DEF  = 1024;
  localparam int unsigned MAX_COLS_DEF  = 1024;
  localparam int unsigned HIT_WIDTH_DEF = 16;

  // Fixed field widths.
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned LINE_W     = 10;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned OUT_LINE_W = 11;
  localparam int unsigned THR_W      = 16;
  localparam int unsigned USE_W      = 11;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Input modes.
  localparam logic [MODE_W-1:0] MODE_COUNT    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_BUILD    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FILTER   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_READ_ROW = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ_COL = 3'd4;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ENTRY    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BUILT    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ_OK  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD_POS  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_USE  = 2'd2;

  // Write strobes from the sequencer to one axis.
  typedef struct packed {
    logic clr_we;
    logic cnt_we;
    logic bld_start;
    logic bld_we;
  } axis_ctl_t;

endpackage

// File: src/spfsp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for all line tables of the projection unit. No dependencies.
`timescale 1ns / 1ps

module spfsp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/spfsp_axis.sv
// One axis (rows or columns): hit/map table, original-index list and kept counter.
// Depends on spfsp_pkg and spfsp_ram.
`timescale 1ns / 1ps

module spfsp_axis #(
  parameter int unsigned DEPTH = spfsp_pkg::MAX_ROWS_DEF,
  parameter int unsigned HIT_W = spfsp_pkg::HIT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  spfsp_pkg::axis_ctl_t             ctl,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic [$clog2(DEPTH)-1:0]         orig_addr,
  input  logic [spfsp_pkg::USE_W-1:0]      in_use,
  input  logic [spfsp_pkg::THR_W-1:0]      threshold,
  output logic                             kept,
  output logic [$clog2(DEPTH)-1:0]         pos,
  output logic [$clog2(DEPTH)-1:0]         orig,
  output logic [$clog2(DEPTH+1)-1:0]       total
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned MW = HIT_W + 1 + IW;

  logic [MW-1:0]    map_rdata;
  logic [MW-1:0]    map_wdata;
  logic             map_we;
  logic [HIT_W-1:0] hits;
  logic [HIT_W-1:0] hits_inc;
  logic             keep;
  logic             orig_we;
  logic [CW-1:0]    n_r;
  logic [CW-1:0]    n_nxt;

  // Map entry layout: hit counter, kept flag, dense position.
  assign hits     = map_rdata[MW-1 -: HIT_W];
  assign kept     = map_rdata[IW];
  assign pos      = map_rdata[IW-1:0];
  assign hits_inc = (hits == {HIT_W{1'b1}}) ? hits : hits + 1'b1;

  // A line is kept when it lies inside the matrix and its count beats the threshold.
  assign keep = (32'(wr_addr) < 32'(in_use)) && (32'(hits) > 32'(threshold));

  assign map_we  = ctl.clr_we | ctl.cnt_we | ctl.bld_we;
  assign orig_we = ctl.bld_we & keep;

  always_comb begin
    if (ctl.clr_we) begin
      map_wdata = '0;
    end else if (ctl.cnt_we) begin
      map_wdata = {hits_inc, kept, pos};
    end else begin
      map_wdata = {hits, keep, keep ? IW'(n_r) : {IW{1'b0}}};
    end
  end

  always_comb begin
    n_nxt = n_r;
    if (ctl.bld_start) begin
      n_nxt = '0;
    end else if (orig_we) begin
      n_nxt = n_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r <= '0;
    end else begin
      n_r <= n_nxt;
    end
  end

  assign total = n_r;

  spfsp_ram #(
    .WIDTH(MW),
    .DEPTH(DEPTH)
  ) u_map_ram (
    .clk  (clk),
    .we   (map_we),
    .waddr(wr_addr),
    .wdata(map_wdata),
    .raddr(rd_addr),
    .rdata(map_rdata)
  );

  spfsp_ram #(
    .WIDTH(IW),
    .DEPTH(DEPTH)
  ) u_orig_ram (
    .clk  (clk),
    .we   (orig_we),
    .waddr(IW'(n_r)),
    .wdata(wr_addr),
    .raddr(orig_addr),
    .rdata(orig)
  );

endmodule

// File: src/sparse_frequent_submatrix_projection_unit.sv
// Top level of the sparse frequent-submatrix projection unit.
// Depends on spfsp_pkg, spfsp_axis and spfsp_ram.
`timescale 1ns / 1ps

// The host streams the nonzero entries of a sparse matrix through this block twice. In the count
// pass (mode 0) every entry inside the matrix bumps a saturating hit counter for its row and for
// its column. A build (mode 1) walks all rows and all columns in parallel, gives every line in
// use whose count exceeds the threshold the next dense position, records its original index, and
// returns one transfer with the kept row and column counts. In the filter pass (mode 2) an entry
// inside the matrix whose row and column are both kept leaves with remapped coordinates and its
// value untouched; other entries produce nothing. Modes 3 and 4 return the original row or column
// index stored at a dense position. Counters and maps live in one table RAM per axis, with a
// second RAM per axis for the original-index lists. Count and build items read the tables and
// write modified entries back; filter and read items only read. Items are handled one at a time:
// a count, filter or read item has its entry read while idle and is finished in the execute
// state, and a build sweeps the tables one entry per cycle. After reset a clearing pass zeroes
// the tables; in_ready stays low during it while configuration writes are taken.
// The output register lets the next item be taken while a result still waits for out_ready.
// Configuration may be written only while no item is in flight.

module sparse_frequent_submatrix_projection_unit #(
  parameter int unsigned MAX_ROWS  = spfsp_pkg::MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS  = spfsp_pkg::MAX_COLS_DEF,
  parameter int unsigned HIT_WIDTH = spfsp_pkg::HIT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [spfsp_pkg::MODE_W-1:0]        in_mode,
  input  logic [spfsp_pkg::LINE_W-1:0]        in_src_row,
  input  logic [spfsp_pkg::LINE_W-1:0]        in_src_col,
  input  logic [spfsp_pkg::LINE_W-1:0]        in_position,
  input  logic [spfsp_pkg::VALUE_W-1:0]       in_entry_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [spfsp_pkg::KIND_W-1:0]        out_kind,
  output logic [spfsp_pkg::OUT_LINE_W-1:0]    out_row,
  output logic [spfsp_pkg::OUT_LINE_W-1:0]    out_col,
  output logic [spfsp_pkg::VALUE_W-1:0]       out_value,
  input  logic                                cfg_we,
  input  logic [spfsp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [spfsp_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int unsigned RIW        = $clog2(MAX_ROWS);
  localparam int unsigned CIW        = $clog2(MAX_COLS);
  localparam int unsigned RCW        = $clog2(MAX_ROWS + 1);
  localparam int unsigned CCW        = $clog2(MAX_COLS + 1);
  localparam int unsigned WALK_DEPTH = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int unsigned WALK_W     = $clog2(WALK_DEPTH);
  localparam logic [WALK_W-1:0] WALK_LAST = WALK_W'(WALK_DEPTH - 1);
  localparam int unsigned OLW        = spfsp_pkg::OUT_LINE_W;
  localparam int unsigned UW         = spfsp_pkg::USE_W;

  // Lines in use after reset: 1024, held within the table depth.
  localparam logic [UW-1:0] ROWS_RST = UW'((MAX_ROWS < 1024) ? MAX_ROWS : 1024);
  localparam logic [UW-1:0] COLS_RST = UW'((MAX_COLS < 1024) ? MAX_COLS : 1024);

  // Sequencer states.
  localparam logic [1:0] ST_CLR   = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_BUILD = 2'd3;

  // A line count of zero is held as one, and one above the table depth as the depth.
  function automatic logic [UW-1:0] clamp_lines(input logic [UW-1:0] v,
                                                input int unsigned maxv);
    logic [UW-1:0] res;
    if (v == '0) begin
      res = UW'(1);
    end else if (32'(v) > maxv) begin
      res = UW'(maxv);
    end else begin
      res = v;
    end
    return res;
  endfunction

  logic [1:0]        state_r, state_nxt;
  logic [WALK_W-1:0] walk_idx_r, walk_idx_nxt;
  logic              walk_issue_r, walk_issue_nxt;
  logic              walk_vld_r, walk_vld_nxt;
  logic [WALK_W-1:0] walk_wr_idx_r, walk_wr_idx_nxt;

  logic [spfsp_pkg::MODE_W-1:0]  mode_r;
  logic [spfsp_pkg::LINE_W-1:0]  row_r;
  logic [spfsp_pkg::LINE_W-1:0]  col_r;
  logic [spfsp_pkg::LINE_W-1:0]  pos_r;
  logic [spfsp_pkg::VALUE_W-1:0] value_r;

  logic [spfsp_pkg::THR_W-1:0] thr_r;
  logic [UW-1:0]               rows_use_r;
  logic [UW-1:0]               cols_use_r;

  logic                           out_valid_r;
  logic [spfsp_pkg::KIND_W-1:0]   out_kind_r;
  logic [OLW-1:0]                 out_row_r;
  logic [OLW-1:0]                 out_col_r;
  logic [spfsp_pkg::VALUE_W-1:0]  out_value_r;

  logic in_acc;
  logic in_matrix;
  logic out_free;
  logic out_load;

  logic                           res_vld;
  logic [spfsp_pkg::KIND_W-1:0]   res_kind;
  logic [OLW-1:0]                 res_row;
  logic [OLW-1:0]                 res_col;
  logic [spfsp_pkg::VALUE_W-1:0]  res_value;

  spfsp_pkg::axis_ctl_t row_ctl, col_ctl;
  logic [RIW-1:0] row_rd_addr, row_wr_addr, row_orig_addr;
  logic [CIW-1:0] col_rd_addr, col_wr_addr, col_orig_addr;
  logic           row_kept, col_kept;
  logic [RIW-1:0] row_pos, row_orig;
  logic [CIW-1:0] col_pos, col_orig;
  logic [RCW-1:0] row_total;
  logic [CCW-1:0] col_total;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid & in_ready;
  assign in_matrix = (32'(row_r) < 32'(rows_use_r)) && (32'(col_r) < 32'(cols_use_r));
  assign out_free  = !out_valid_r || out_ready;

  // Table addressing. While idle the read address comes straight from the input port, so the
  // entry is ready in the execute cycle; during execute the latched item keeps the data steady.
  always_comb begin
    case (state_r)
      ST_IDLE: begin
        row_rd_addr = RIW'(in_src_row);
        col_rd_addr = CIW'(in_src_col);
        row_wr_addr = RIW'(row_r);
        col_wr_addr = CIW'(col_r);
      end
      ST_EXEC: begin
        row_rd_addr = RIW'(row_r);
        col_rd_addr = CIW'(col_r);
        row_wr_addr = RIW'(row_r);
        col_wr_addr = CIW'(col_r);
      end
      ST_BUILD: begin
        row_rd_addr = RIW'(walk_idx_r);
        col_rd_addr = CIW'(walk_idx_r);
        row_wr_addr = RIW'(walk_wr_idx_r);
        col_wr_addr = CIW'(walk_wr_idx_r);
      end
      default: begin
        row_rd_addr = RIW'(walk_idx_r);
        col_rd_addr = CIW'(walk_idx_r);
        row_wr_addr = RIW'(walk_idx_r);
        col_wr_addr = CIW'(walk_idx_r);
      end
    endcase
  end

  assign row_orig_addr = (state_r == ST_IDLE) ? RIW'(in_position) : RIW'(pos_r);
  assign col_orig_addr = (state_r == ST_IDLE) ? CIW'(in_position) : CIW'(pos_r);

  // Write strobes. The sweep covers the deeper axis; the shallower one skips the excess.
  always_comb begin
    row_ctl.clr_we    = (state_r == ST_CLR) && (32'(walk_idx_r) < MAX_ROWS);
    col_ctl.clr_we    = (state_r == ST_CLR) && (32'(walk_idx_r) < MAX_COLS);
    row_ctl.cnt_we    = (state_r == ST_EXEC) && (mode_r == spfsp_pkg::MODE_COUNT) && in_matrix;
    col_ctl.cnt_we    = row_ctl.cnt_we;
    row_ctl.bld_start = in_acc && (in_mode == spfsp_pkg::MODE_BUILD);
    col_ctl.bld_start = row_ctl.bld_start;
    row_ctl.bld_we    = (state_r == ST_BUILD) && walk_vld_r && (32'(walk_wr_idx_r) < MAX_ROWS);
    col_ctl.bld_we    = (state_r == ST_BUILD) && walk_vld_r && (32'(walk_wr_idx_r) < MAX_COLS);
  end

  // Result of the item in the execute cycle.
  always_comb begin
    res_vld   = 1'b0;
    res_kind  = spfsp_pkg::KIND_ENTRY;
    res_row   = '0;
    res_col   = '0;
    res_value = '0;
    case (mode_r)
      spfsp_pkg::MODE_BUILD: begin
        res_vld  = 1'b1;
        res_kind = spfsp_pkg::KIND_BUILT;
        res_row  = OLW'(row_total);
        res_col  = OLW'(col_total);
      end
      spfsp_pkg::MODE_FILTER: begin
        if (in_matrix && row_kept && col_kept) begin
          res_vld   = 1'b1;
          res_kind  = spfsp_pkg::KIND_ENTRY;
          res_row   = OLW'(row_pos);
          res_col   = OLW'(col_pos);
          res_value = value_r;
        end
      end
      spfsp_pkg::MODE_READ_ROW: begin
        res_vld = 1'b1;
        if (32'(pos_r) < 32'(row_total)) begin
          res_kind = spfsp_pkg::KIND_READ_OK;
          res_row  = OLW'(row_orig);
        end else begin
          res_kind = spfsp_pkg::KIND_BAD_POS;
        end
      end
      spfsp_pkg::MODE_READ_COL: begin
        res_vld = 1'b1;
        if (32'(pos_r) < 32'(col_total)) begin
          res_kind = spfsp_pkg::KIND_READ_OK;
          res_col  = OLW'(col_orig);
        end else begin
          res_kind = spfsp_pkg::KIND_BAD_POS;
        end
      end
      default: begin
        res_vld = 1'b0;
      end
    endcase
  end

  assign out_load = (state_r == ST_EXEC) && res_vld && out_free;

  // Sequencer: clearing sweep, idle, execute, and the build sweep. The build sweep reads one
  // index per cycle and writes the index read the cycle before, so reads and writes never meet.
  always_comb begin
    state_nxt       = state_r;
    walk_idx_nxt    = walk_idx_r;
    walk_issue_nxt  = walk_issue_r;
    walk_vld_nxt    = walk_vld_r;
    walk_wr_idx_nxt = walk_wr_idx_r;
    case (state_r)
      ST_CLR: begin
        if (walk_idx_r == WALK_LAST) begin
          walk_idx_nxt = '0;
          state_nxt    = ST_IDLE;
        end else begin
          walk_idx_nxt = walk_idx_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_mode == spfsp_pkg::MODE_BUILD) begin
            state_nxt      = ST_BUILD;
            walk_idx_nxt   = '0;
            walk_issue_nxt = 1'b1;
            walk_vld_nxt   = 1'b0;
          end else begin
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_BUILD: begin
        walk_vld_nxt    = walk_issue_r;
        walk_wr_idx_nxt = walk_idx_r;
        if (walk_issue_r) begin
          if (walk_idx_r == WALK_LAST) begin
            walk_issue_nxt = 1'b0;
            walk_idx_nxt   = '0;
          end else begin
            walk_idx_nxt = walk_idx_r + 1'b1;
          end
        end else if (!walk_vld_r) begin
          // Sweep drained: report the totals from the execute state.
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!res_vld || out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLR;
      walk_idx_r    <= '0;
      walk_issue_r  <= 1'b0;
      walk_vld_r    <= 1'b0;
      walk_wr_idx_r <= '0;
    end else begin
      state_r       <= state_nxt;
      walk_idx_r    <= walk_idx_nxt;
      walk_issue_r  <= walk_issue_nxt;
      walk_vld_r    <= walk_vld_nxt;
      walk_wr_idx_r <= walk_wr_idx_nxt;
    end
  end

  // Latched item fields.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r  <= in_mode;
      row_r   <= in_src_row;
      col_r   <= in_src_col;
      pos_r   <= in_position;
      value_r <= in_entry_value;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r      <= '0;
      rows_use_r <= ROWS_RST;
      cols_use_r <= COLS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        spfsp_pkg::CFG_THRESHOLD: thr_r      <= cfg_wdata;
        spfsp_pkg::CFG_ROWS_USE:  rows_use_r <= clamp_lines(cfg_wdata[UW-1:0], MAX_ROWS);
        spfsp_pkg::CFG_COLS_USE:  cols_use_r <= clamp_lines(cfg_wdata[UW-1:0], MAX_COLS);
        default: begin
        end
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r  <= res_kind;
      out_row_r   <= res_row;
      out_col_r   <= res_col;
      out_value_r <= res_value;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_value = out_value_r;

  spfsp_axis #(
    .DEPTH(MAX_ROWS),
    .HIT_W(HIT_WIDTH)
  ) u_row_axis (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (row_ctl),
    .rd_addr  (row_rd_addr),
    .wr_addr  (row_wr_addr),
    .orig_addr(row_orig_addr),
    .in_use   (rows_use_r),
    .threshold(thr_r),
    .kept     (row_kept),
    .pos      (row_pos),
    .orig     (row_orig),
    .total    (row_total)
  );

  spfsp_axis #(
    .DEPTH(MAX_COLS),
    .HIT_W(HIT_WIDTH)
  ) u_col_axis (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (col_ctl),
    .rd_addr  (col_rd_addr),
    .wr_addr  (col_wr_addr),
    .orig_addr(col_orig_addr),
    .in_use   (cols_use_r),
    .threshold(thr_r),
    .kept     (col_kept),
    .pos      (col_pos),
    .orig     (col_orig),
    .total    (col_total)
  );

endmodule

// File: bench/sparse_frequent_submatrix_projection_unit_tb.sv
// Self-checking testbench for sparse_frequent_submatrix_projection_unit.
// Holds its own bit-accurate prediction of the count, build, filter and read behavior.
// Depends on spfsp_pkg and the RTL of the unit only.
`timescale 1ns / 1ps

module sparse_frequent_submatrix_projection_unit_tb;

  localparam int NUM_LINES      = 1024;
  localparam int HIT_MAX        = 65535;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 1100;
  localparam int REPORT_CAP     = 60;
  localparam int SAT_ROW        = 7;
  localparam int SAT_COL        = 9;
  localparam int HOT_COUNT      = 24;

  localparam int MW  = spfsp_pkg::MODE_W;
  localparam int LW  = spfsp_pkg::LINE_W;
  localparam int VW  = spfsp_pkg::VALUE_W;
  localparam int KW  = spfsp_pkg::KIND_W;
  localparam int OLW = spfsp_pkg::OUT_LINE_W;
  localparam int IXW = spfsp_pkg::CFG_IDX_W;
  localparam int DW  = spfsp_pkg::CFG_DATA_W;
  localparam int UW  = spfsp_pkg::USE_W;

  // Modes the unit ignores; they must produce nothing.
  localparam logic [MW-1:0] MODE_SPARE_5 = 3'd5;
  localparam logic [MW-1:0] MODE_SPARE_6 = 3'd6;
  localparam logic [MW-1:0] MODE_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [MW-1:0] mode;
    logic [LW-1:0] src_row;
    logic [LW-1:0] src_col;
    logic [LW-1:0] position;
    logic [VW-1:0] value;
  } entry_item_t;

  typedef struct packed {
    logic [KW-1:0]  kind;
    logic [OLW-1:0] row;
    logic [OLW-1:0] col;
    logic [VW-1:0]  value;
  } proj_result_t;

  // How a row of the directed table is checked: by the predictor, as silent, or against a
  // result typed into the table.
  typedef enum logic [1:0] {CHECK_PREDICT, CHECK_QUIET, CHECK_TYPED} check_style_t;

  typedef struct {
    bit             is_cfg;
    logic [IXW-1:0] cfg_idx;
    logic [DW-1:0]  cfg_data;
    entry_item_t    item;
    check_style_t   style;
    proj_result_t   typed;
  } stim_row_t;

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  logic [MW-1:0]  in_mode;
  logic [LW-1:0]  in_src_row;
  logic [LW-1:0]  in_src_col;
  logic [LW-1:0]  in_position;
  logic [VW-1:0]  in_entry_value;
  logic           out_valid;
  logic           out_ready = 1'b0;
  logic [KW-1:0]  out_kind;
  logic [OLW-1:0] out_row;
  logic [OLW-1:0] out_col;
  logic [VW-1:0]  out_value;
  logic           cfg_we;
  logic [IXW-1:0] cfg_index;
  logic [DW-1:0]  cfg_wdata;

  // Idle rates of the two sides, in percent of cycles.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  int mismatch_count = 0;
  int stuck_cycles   = 0;

  // Results the unit still owes, oldest first.
  proj_result_t projected_results[$];
  stim_row_t    directed_rows[$];

  // Shadow of the unit's registers and tables.
  logic [spfsp_pkg::THR_W-1:0] thr_cfg;
  logic [UW-1:0]               rows_cfg;
  logic [UW-1:0]               cols_cfg;
  logic [15:0]                 row_hits [NUM_LINES];
  logic [15:0]                 col_hits [NUM_LINES];
  bit                          row_kept [NUM_LINES];
  bit                          col_kept [NUM_LINES];
  logic [OLW-1:0]              row_pos  [NUM_LINES];
  logic [OLW-1:0]              col_pos  [NUM_LINES];
  logic [LW-1:0]               row_orig [NUM_LINES];
  logic [LW-1:0]               col_orig [NUM_LINES];
  logic [OLW-1:0]              kept_rows;
  logic [OLW-1:0]              kept_cols;

  sparse_frequent_submatrix_projection_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_src_row     (in_src_row),
    .in_src_col     (in_src_col),
    .in_position    (in_position),
    .in_entry_value (in_entry_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_value      (out_value),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // The line count registers keep eleven bits of the written word. Zero is held as one line
  // and anything above the table depth is held as the full depth.
  function automatic logic [UW-1:0] clamp_lines(input logic [DW-1:0] data);
    logic [UW-1:0] lines;
    lines = data[UW-1:0];
    if (lines == '0) return UW'(1);
    if (lines > UW'(NUM_LINES)) return UW'(NUM_LINES);
    return lines;
  endfunction

  // Predicts what one accepted item does to the tables and returns whether it yields a result.
  function automatic bit project_item(input entry_item_t it, output proj_result_t res);
    bit in_matrix;
    res = '0;
    in_matrix = (UW'(it.src_row) < rows_cfg) && (UW'(it.src_col) < cols_cfg);
    case (it.mode)
      spfsp_pkg::MODE_COUNT: begin
        // Entries outside the matrix are not counted at all; counters saturate.
        if (in_matrix) begin
          if (row_hits[it.src_row] != 16'(HIT_MAX)) row_hits[it.src_row]++;
          if (col_hits[it.src_col] != 16'(HIT_MAX)) col_hits[it.src_col]++;
        end
        return 1'b0;
      end
      spfsp_pkg::MODE_BUILD: begin
        // Rows and columns are walked independently; lines at or above the number in use are
        // never kept, so a rebuild with fewer lines drops them.
        kept_rows = '0;
        kept_cols = '0;
        for (int i = 0; i < NUM_LINES; i++) begin
          row_kept[i] = 1'b0;
          row_pos[i]  = '0;
          if (i < int'(rows_cfg) && row_hits[i] > thr_cfg) begin
            row_kept[i]             = 1'b1;
            row_pos[i]              = kept_rows;
            row_orig[LW'(kept_rows)] = LW'(i);
            kept_rows++;
          end
          col_kept[i] = 1'b0;
          col_pos[i]  = '0;
          if (i < int'(cols_cfg) && col_hits[i] > thr_cfg) begin
            col_kept[i]             = 1'b1;
            col_pos[i]              = kept_cols;
            col_orig[LW'(kept_cols)] = LW'(i);
            kept_cols++;
          end
        end
        res.kind = spfsp_pkg::KIND_BUILT;
        res.row  = kept_rows;
        res.col  = kept_cols;
        return 1'b1;
      end
      spfsp_pkg::MODE_FILTER: begin
        if (in_matrix && row_kept[it.src_row] && col_kept[it.src_col]) begin
          res.kind  = spfsp_pkg::KIND_ENTRY;
          res.row   = row_pos[it.src_row];
          res.col   = col_pos[it.src_col];
          res.value = it.value;
          return 1'b1;
        end
        return 1'b0;
      end
      spfsp_pkg::MODE_READ_ROW: begin
        if (OLW'(it.position) < kept_rows) begin
          res.kind = spfsp_pkg::KIND_READ_OK;
          res.row  = OLW'(row_orig[it.position]);
        end else begin
          res.kind = spfsp_pkg::KIND_BAD_POS;
        end
        return 1'b1;
      end
      spfsp_pkg::MODE_READ_COL: begin
        if (OLW'(it.position) < kept_cols) begin
          res.kind = spfsp_pkg::KIND_READ_OK;
          res.col  = OLW'(col_orig[it.position]);
        end else begin
          res.kind = spfsp_pkg::KIND_BAD_POS;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic entry_item_t make_item(input logic [MW-1:0] mode, input int r, c, p,
                                            input logic [VW-1:0] v);
    entry_item_t it;
    it.mode     = mode;
    it.src_row  = LW'(r);
    it.src_col  = LW'(c);
    it.position = LW'(p);
    it.value    = v;
    return it;
  endfunction

  function automatic void add_item(input logic [MW-1:0] mode, input int r, c, p,
                                   input logic [VW-1:0] v, input check_style_t style,
                                   input logic [KW-1:0] kind, input int orow, ocol,
                                   input logic [VW-1:0] oval);
    stim_row_t row;
    row.is_cfg      = 1'b0;
    row.cfg_idx     = '0;
    row.cfg_data    = '0;
    row.item        = make_item(mode, r, c, p, v);
    row.style       = style;
    row.typed.kind  = kind;
    row.typed.row   = OLW'(orow);
    row.typed.col   = OLW'(ocol);
    row.typed.value = oval;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic void add_cfg(input logic [IXW-1:0] idx, input logic [DW-1:0] data);
    stim_row_t row;
    row.is_cfg   = 1'b1;
    row.cfg_idx  = idx;
    row.cfg_data = data;
    row.item     = '0;
    row.style    = CHECK_QUIET;
    row.typed    = '0;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // Mostly a line of the hot set, now and then any line at all, which may lie outside.
  function automatic int pick_line(input int base, input int span);
    if ($urandom_range(99) < 85) return base + int'($urandom_range(span - 1));
    return int'($urandom_range(NUM_LINES - 1));
  endfunction

  function automatic logic [DW-1:0] random_line_count();
    int pick;
    pick = int'($urandom_range(9));
    if (pick == 0) return DW'(1);
    if (pick == 1) return DW'(NUM_LINES);
    if (pick == 2) return DW'($urandom_range(16'hFFFF));
    return DW'($urandom_range(64, 2));
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < REPORT_CAP)
      $display("%0t ns: mismatch in %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Presents one item, holds it until the transfer, and updates the prediction at that edge.
  // Returns right at the accepting rising edge; the next call starts at the falling edge.
  task automatic send_item(input entry_item_t it, input bit predicted);
    proj_result_t res;
    bit           has_res;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= it.mode;
    in_src_row     <= it.src_row;
    in_src_col     <= it.src_col;
    in_position    <= it.position;
    in_entry_value <= it.value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    has_res = project_item(it, res);
    if (predicted && has_res) projected_results.insert(projected_results.size(), res);
  endtask

  // Stops sending and waits until every owed result has arrived, then lets the unit settle so
  // that a trailing count or filter item, which returns nothing, has left the pipeline.
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (projected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [IXW-1:0] idx, input logic [DW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      spfsp_pkg::CFG_THRESHOLD: thr_cfg  = data;
      spfsp_pkg::CFG_ROWS_USE:  rows_cfg = clamp_lines(data);
      spfsp_pkg::CFG_COLS_USE:  cols_cfg = clamp_lines(data);
      default: ;
    endcase
  endtask

  // One well-formed pass over a fresh configuration: counts on a hot set of lines, a build,
  // filtered entries on the same lines, and reads around the kept totals. A little noise is
  // mixed in, and now and then the build is skipped or repeated. The setting argument forces
  // the register extremes: 1 for all rows and a single column, 2 for the reverse.
  task automatic run_round(input int setting);
    logic [DW-1:0] thr;
    logic [DW-1:0] rows;
    logic [DW-1:0] cols;
    int            pick;
    int            span_r;
    int            span_c;
    int            base_r;
    int            base_c;
    entry_item_t   it;
    drain_results();
    pick = int'($urandom_range(9));
    if (pick == 0) thr = '0;
    else if (pick == 1) thr = 16'hFFFF;
    else if (pick == 2) thr = 16'hFFFE;
    else thr = DW'($urandom_range(6));
    rows = random_line_count();
    cols = random_line_count();
    if (setting == 1) begin
      thr  = '0;
      rows = DW'(NUM_LINES);
      cols = DW'(1);
    end else if (setting == 2) begin
      thr  = 16'hFFFF;
      rows = DW'(1);
      cols = DW'(NUM_LINES);
    end
    write_register(spfsp_pkg::CFG_THRESHOLD, thr);
    write_register(spfsp_pkg::CFG_ROWS_USE, rows);
    write_register(spfsp_pkg::CFG_COLS_USE, cols);

    span_r = int'($urandom_range(12, 2));
    if (span_r > int'(rows_cfg)) span_r = int'(rows_cfg);
    span_c = int'($urandom_range(12, 2));
    if (span_c > int'(cols_cfg)) span_c = int'(cols_cfg);
    base_r = int'($urandom_range(int'(rows_cfg) - span_r));
    base_c = int'($urandom_range(int'(cols_cfg) - span_c));

    repeat ($urandom_range(25, 15)) begin
      it = make_item(spfsp_pkg::MODE_COUNT, pick_line(base_r, span_r),
                     pick_line(base_c, span_c), int'($urandom_range(NUM_LINES - 1)),
                     $urandom());
      if ($urandom_range(99) < 8) it.mode = MW'($urandom_range(7));
      send_item(it, 1'b1);
    end
    if ($urandom_range(9) != 0)
      send_item(make_item(spfsp_pkg::MODE_BUILD, int'($urandom_range(NUM_LINES - 1)),
                          int'($urandom_range(NUM_LINES - 1)),
                          int'($urandom_range(NUM_LINES - 1)), $urandom()), 1'b1);
    repeat ($urandom_range(20, 12)) begin
      it = make_item(spfsp_pkg::MODE_FILTER, pick_line(base_r, span_r),
                     pick_line(base_c, span_c), int'($urandom_range(NUM_LINES - 1)),
                     $urandom());
      if ($urandom_range(99) < 8) it.mode = MW'($urandom_range(7));
      send_item(it, 1'b1);
    end
    // Positions mostly from zero up to the kept totals, so both outcomes of a read occur.
    repeat (4) begin
      it = make_item(spfsp_pkg::MODE_READ_ROW, int'($urandom_range(NUM_LINES - 1)),
                     int'($urandom_range(NUM_LINES - 1)),
                     ($urandom_range(3) != 0) ? int'($urandom_range(int'(kept_rows)))
                                              : int'($urandom_range(NUM_LINES - 1)),
                     $urandom());
      send_item(it, 1'b1);
      it = make_item(spfsp_pkg::MODE_READ_COL, int'($urandom_range(NUM_LINES - 1)),
                     int'($urandom_range(NUM_LINES - 1)),
                     ($urandom_range(3) != 0) ? int'($urandom_range(int'(kept_cols)))
                                              : int'($urandom_range(NUM_LINES - 1)),
                     $urandom());
      send_item(it, 1'b1);
    end
    if ($urandom_range(3) == 0)
      send_item(make_item(spfsp_pkg::MODE_BUILD, 0, 0, 0, $urandom()), 1'b1);
  endtask

  // Receiver side: out_ready follows the current stall rate, changing at the falling edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Every result transfer is checked against the oldest owed result, field by field.
  always @(posedge clk) begin : check_results
    proj_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (projected_results.size() == 0) begin
        report_mismatch("result with nothing owed, kind", 32'(out_kind), '0);
      end else begin
        want = projected_results.pop_front();
        if (out_kind !== want.kind)   report_mismatch("out_kind", 32'(out_kind), 32'(want.kind));
        if (out_row !== want.row)     report_mismatch("out_row", 32'(out_row), 32'(want.row));
        if (out_col !== want.col)     report_mismatch("out_col", 32'(out_col), 32'(want.col));
        if (out_value !== want.value) report_mismatch("out_value", out_value, want.value);
      end
    end
  end

  // The run is stuck when neither channel completes a transfer for a long stretch. The limit
  // covers the clearing pass, a full build sweep and long receiver stalls several times over.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("** sparse_frequent_submatrix_projection_unit: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t row;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_mode        = '0;
    in_src_row     = '0;
    in_src_col     = '0;
    in_position    = '0;
    in_entry_value = '0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;

    // Shadow state after reset: nothing counted, nothing kept, full matrix, threshold zero.
    thr_cfg   = '0;
    rows_cfg  = UW'(NUM_LINES);
    cols_cfg  = UW'(NUM_LINES);
    kept_rows = '0;
    kept_cols = '0;
    for (int i = 0; i < NUM_LINES; i++) begin
      row_hits[i] = '0;
      col_hits[i] = '0;
      row_kept[i] = 1'b0;
      col_kept[i] = 1'b0;
      row_pos[i]  = '0;
      col_pos[i]  = '0;
      row_orig[i] = '0;
      col_orig[i] = '0;
    end

    // Directed table. Typed results are the ones that follow directly from the rules: reads
    // and builds before anything is kept, the corner lines, and the kept counts after the
    // row count register is clamped.
    add_item(spfsp_pkg::MODE_READ_ROW, 0, 0, 0, '0, CHECK_TYPED,
             spfsp_pkg::KIND_BAD_POS, 0, 0, '0);
    add_item(spfsp_pkg::MODE_READ_COL, 0, 0, 1023, '0, CHECK_TYPED,
             spfsp_pkg::KIND_BAD_POS, 0, 0, '0);
    add_item(spfsp_pkg::MODE_FILTER, 0, 0, 0, 32'hFFFF_FFFF, CHECK_QUIET,
             spfsp_pkg::KIND_ENTRY, 0, 0, '0);
    add_item(spfsp_pkg::MODE_BUILD, 0, 0, 0, '0, CHECK_TYPED,
             spfsp_pkg::KIND_BUILT, 0, 0, '0);
    add_item(MODE_SPARE_5, 0, 0, 0, '0, CHECK_QUIET, spfsp_pkg::KIND_ENTRY, 0, 0, '0);
    add_item(MODE_SPARE_6, 512, 1, 2, 32'h5555_AAAA, CHECK_QUIET,
             spfsp_pkg::KIND_ENTRY, 0, 0, '0);
    add_item(MODE_SPARE_7, 1023, 1023, 1023, 32'hFFFF_FFFF, CHECK_QUIET,
             spfsp_pkg::KIND_ENTRY, 0, 0, '0);
    add_item(spfsp_pkg::MODE_COUNT, 0, 0, 0, '0, CHECK_PREDICT,
             spfsp_pkg::KIND_ENTRY, 0, 0, '0);
    add_item(spfsp_pkg::MODE_COUNT, 1023, 1023, 1023, 32'hFFFF_FFFF, CHECK_PREDICT,
             spfsp_pkg::KIND_ENTRY, 0, 0, '0);
    add_item(spfsp_pkg::MODE_COUNT, 1023, 0, 0, '0, CHECK_PREDICT,
             spfsp_pkg::KIND_ENTRY, 0, 0, '0);
    add_item(spfsp_pkg::MODE_COUNT, 0, 1023, 0, '0, CHECK_PREDICT,
             spfsp_pkg::KIND_ENTRY, 0, 0, '0);
    add_item(spfsp_pkg::MODE_BUILD, 0, 0, 0, '0, CHECK_TYPED,
             spfsp_pkg::KIND_BUILT, 2, 2, '0);
    add_item(spfsp_pkg::MODE_READ_ROW, 0, 0, 0, '0, CHECK_TYPED,
             spfsp_pkg::KIND_READ_OK, 0, 0, '0);
    add_item(spfsp_pkg::MODE_READ_ROW, 0, 0, 1, '0, CHECK_TYPED,
             spfsp_pkg::KIND_READ_OK, 1023, 0, '0);
    add_item(spfsp_pkg::MODE_READ_ROW, 0, 0, 2, '0, CHECK_TYPED,
             spfsp_pkg::KIND_BAD_POS, 0, 0, '0);
    add_item(spfsp_pkg::MODE_READ_COL, 0, 0, 1, '0, CHECK_TYPED,
             spfsp_pkg::KIND_READ_OK, 0, 1023, '0);
    add_item(spfsp_pkg::MODE_FILTER, 1023, 0, 0, 32'hFFFF_FFFF, CHECK_TYPED,
             spfsp_pkg::KIND_ENTRY, 1, 0, 32'hFFFF_FFFF);
    add_item(spfsp_pkg::MODE_FILTER, 0, 1023, 0, '0, CHECK_TYPED,
             spfsp_pkg::KIND_ENTRY, 0, 1, '0);
    add_item(spfsp_pkg::MODE_FILTER, 1023, 1023, 0, 32'hA5A5_5A5A, CHECK_PREDICT,
             spfsp_pkg::KIND_ENTRY, 0, 0, '0);
    add_item(spfsp_pkg::MODE_FILTER, 5, 0, 0, 32'h1234_5678, CHECK_PREDICT,
             spfsp_pkg::KIND_ENTRY, 0, 0, '0);
    // A written zero leaves one row in use, so row 1 and up fall outside the matrix.
    add_cfg(spfsp_pkg::CFG_ROWS_USE, '0);
    add_item(spfsp_pkg::MODE_COUNT, 1, 0, 0, '0, CHECK_PREDICT,
             spfsp_pkg::KIND_ENTRY, 0, 0, '0);
    add_item(spfsp_pkg::MODE_FILTER, 1023, 0, 0, 32'h0F0F_0F0F, CHECK_PREDICT,
             spfsp_pkg::KIND_ENTRY, 0, 0, '0);
    add_item(spfsp_pkg::MODE_BUILD, 0, 0, 0, '0, CHECK_TYPED,
             spfsp_pkg::KIND_BUILT, 1, 2, '0);
    // An oversized row count is held at the full depth; row 1023 lost its place in the rebuild.
    add_cfg(spfsp_pkg::CFG_ROWS_USE, 16'hFFFF);
    add_item(spfsp_pkg::MODE_FILTER, 1023, 0, 0, 32'h0F0F_0F0F, CHECK_PREDICT,
             spfsp_pkg::KIND_ENTRY, 0, 0, '0);
    add_item(spfsp_pkg::MODE_READ_ROW, 0, 0, 1, '0, CHECK_TYPED,
             spfsp_pkg::KIND_BAD_POS, 0, 0, '0);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[k]) begin
      row = directed_rows[k];
      if (row.is_cfg) begin
        drain_results();
        write_register(row.cfg_idx, row.cfg_data);
      end else begin
        send_item(row.item, row.style == CHECK_PREDICT);
        if (row.style == CHECK_TYPED)
          projected_results.insert(projected_results.size(), row.typed);
      end
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 77; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 77; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      if (phase == 0) begin
        // Drive one row and one column well above every other line. At the top threshold
        // nothing can exceed it; just below their count, exactly that row and column are kept.
        drain_results();
        write_register(spfsp_pkg::CFG_THRESHOLD, 16'hFFFF);
        repeat (HOT_COUNT)
          send_item(make_item(spfsp_pkg::MODE_COUNT, SAT_ROW, SAT_COL, 0, $urandom()), 1'b1);
        send_item(make_item(spfsp_pkg::MODE_BUILD, 0, 0, 0, '0), 1'b1);
        drain_results();
        write_register(spfsp_pkg::CFG_THRESHOLD, DW'(HOT_COUNT - 1));
        send_item(make_item(spfsp_pkg::MODE_BUILD, 0, 0, 0, '0), 1'b1);
        send_item(make_item(spfsp_pkg::MODE_FILTER, SAT_ROW, SAT_COL, 0, $urandom()), 1'b1);
      end
      for (int rnd = 0; rnd < 3; rnd++)
        run_round((rnd == 0 && (phase == 1 || phase == 2)) ? phase : 0);
    end

    // Let the receiver take everything that is owed, then watch for stray transfers for
    // longer than a full build takes.
    @(negedge clk);
    in_valid <= 1'b0;
    stall_pct = 0;
    while (projected_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("** sparse_frequent_submatrix_projection_unit: PASSED **");
    end else begin
      $display("** sparse_frequent_submatrix_projection_unit: FAILED **");
    end
    $finish;
  end

endmodule
